/* hw/rtl/cqf_pkg.sv */
// Shared types and constants of the slot admission engine.
package cqf_pkg;

  localparam int DIV_W = 11;
  localparam int CAP_W = 12;
  localparam int CFG_W = 12;
  localparam int OCC_W = 16;
  localparam int OVF_W = 14;
  localparam int PKT_W = 8;
  localparam int OFS_W = 10;

  localparam logic [OVF_W-1:0] OVF_MAX = '1;
  localparam logic [DIV_W-1:0] CYCLE_RESET = 11'd1024;
  localparam logic [CAP_W-1:0] CAP_RESET = 12'd16;

  localparam logic KIND_ADMIT = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic CFG_CYCLE    = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    ST_ADMITTED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_INVALID  = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACC_ADD  = 2'd0,
    ACC_SUB  = 2'd1,
    ACC_ZERO = 2'd2
  } acc_mode_t;

  typedef struct packed {
    logic      valid;
    acc_mode_t mode;
    logic      clr_over;
  } acc_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

/* hw/rtl/cqf_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module cqf_div (
  input  logic              clk,
  input  logic              rst,
  input  cqf_pkg::div_req_t req,
  output cqf_pkg::div_rsp_t rsp
);
  import cqf_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= CNT_W'(DIV_W);
        run <= 1'b1;
      end else if (run) begin
        if (!diff[DIV_W]) begin
          rem <= diff[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

/* hw/rtl/cqf_store.sv */
// Occupancy memory with read-modify-write stage and overflow counter.
module cqf_store #(
  parameter int ADDR_W = 15
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cqf_pkg::acc_t             acc,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [cqf_pkg::PKT_W-1:0] pkts,
  input  logic [cqf_pkg::CAP_W-1:0] capacity,
  output logic [cqf_pkg::OVF_W-1:0] over
);
  import cqf_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [OCC_W-1:0]  mem [DEPTH];
  logic [OCC_W-1:0]  rd_data;
  logic [OCC_W-1:0]  wr_data;
  logic [ADDR_W-1:0] s_addr;
  acc_mode_t         s_mode;
  logic              s_valid;

  always_comb begin
    case (s_mode)
      ACC_ADD:  wr_data = rd_data + {{(OCC_W-PKT_W){1'b0}}, pkts};
      ACC_SUB:  wr_data = rd_data - {{(OCC_W-PKT_W){1'b0}}, pkts};
      ACC_ZERO: wr_data = '0;
      default:  wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[addr];
    s_addr  <= addr;
    s_mode  <= acc.mode;
    if (s_valid) begin
      mem[s_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      over    <= '0;
    end else begin
      s_valid <= acc.valid;
      if (acc.clr_over) begin
        over <= '0;
      end else if (s_valid && s_mode == ACC_ADD &&
                   wr_data > {{(OCC_W-CAP_W){1'b0}}, capacity} && over != OVF_MAX) begin
        over <= over + 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/cqf_seq.sv */
// Sequencer: request checks, divider control, path walk and store sweep.
module cqf_seq #(
  parameter  int NODES  = 8,
  parameter  int PORTS  = 4,
  parameter  int SLOTS  = 1024,
  localparam int NODE_W = $clog2(NODES),
  localparam int PORT_W = $clog2(PORTS),
  localparam int SLOT_W = $clog2(SLOTS),
  localparam int ADDR_W = NODE_W + PORT_W + SLOT_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [2:0]                entry_node,
  input  logic [2:0]                dst_node,
  input  logic [1:0]                dst_host,
  input  logic [cqf_pkg::OFS_W-1:0] start_offset,
  input  logic [cqf_pkg::DIV_W-1:0] flow_period,
  input  logic [cqf_pkg::PKT_W-1:0] pkt_count,
  input  logic [cqf_pkg::DIV_W-1:0] cycle_slots,
  output cqf_pkg::acc_t             acc,
  output logic [ADDR_W-1:0]         addr,
  output logic [cqf_pkg::PKT_W-1:0] pkts,
  input  logic [cqf_pkg::OVF_W-1:0] over,
  output cqf_pkg::div_req_t         div_req,
  input  cqf_pkg::div_rsp_t         div_rsp,
  output logic                      done,
  output cqf_pkg::status_t          status,
  output logic [cqf_pkg::OVF_W-1:0] overflow_slots
);
  import cqf_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DIVMOD = 7'b0000100,
    S_DIVREP = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_CHECK  = 7'b1000000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] sweep;
  logic              clearing;
  logic              report_clear;
  logic              undo;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] node_start;
  logic [NODE_W-1:0] dst_q;
  logic [PORT_W-1:0] port_last;
  logic [DIV_W-1:0]  period_q;
  logic [DIV_W-1:0]  first_base;
  logic [DIV_W-1:0]  hop_base;
  logic [DIV_W-1:0]  slot;
  logic [DIV_W-1:0]  reps;
  logic [DIV_W-1:0]  j;

  logic              invalid;
  logic              accept;
  logic              last_hop;
  logic [PORT_W-1:0] port_sel;
  logic [DIV_W:0]    step_sum;
  logic [DIV_W-1:0]  slot_step;
  logic [DIV_W-1:0]  hop_next;
  logic [DIV_W-1:0]  first_next;
  logic [NODE_W-1:0] node_next;

  function automatic logic [DIV_W-1:0] inc_wrap(input logic [DIV_W-1:0] v,
                                                input logic [DIV_W-1:0] cyc);
    logic [DIV_W-1:0] n;
    n = v + 1'b1;
    return (n == cyc) ? '0 : n;
  endfunction

  always_comb begin
    accept  = start && (state == S_IDLE);
    invalid = (entry_node == dst_node) || (int'(entry_node) >= NODES) ||
              (int'(dst_node) >= NODES) || (int'(dst_host) + 1 >= PORTS) ||
              (flow_period == '0) || (cycle_slots == '0) ||
              (int'(cycle_slots) > SLOTS);
    last_hop   = (node == dst_q);
    port_sel   = last_hop ? port_last : '0;
    step_sum   = {1'b0, slot} + {1'b0, period_q};
    slot_step  = (step_sum >= {1'b0, cycle_slots}) ?
                 DIV_W'(step_sum - {1'b0, cycle_slots}) : step_sum[DIV_W-1:0];
    hop_next   = inc_wrap(hop_base, cycle_slots);
    first_next = inc_wrap(div_rsp.remainder, cycle_slots);
    node_next  = (int'(node) == NODES - 1) ? '0 : node + 1'b1;
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, start_offset};
    div_req.divisor  = cycle_slots;
    if (state == S_DIVMOD) begin
      div_req.start    = div_rsp.done;
      div_req.dividend = cycle_slots;
      div_req.divisor  = period_q;
    end else if (accept && kind == KIND_ADMIT && !invalid) begin
      div_req.start = 1'b1;
    end
  end

  always_comb begin
    acc.valid    = (state == S_WALK) || (state == S_CLEAR);
    acc.mode     = (state == S_CLEAR) ? ACC_ZERO : (undo ? ACC_SUB : ACC_ADD);
    acc.clr_over = accept;
    addr         = (state == S_CLEAR) ? sweep : {node, port_sel, SLOT_W'(slot)};
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      sweep        <= '0;
      clearing     <= 1'b1;
      report_clear <= 1'b0;
      undo         <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == '1) begin
            state <= S_DRAIN;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (kind == KIND_CLEAR) begin
              sweep        <= '0;
              clearing     <= 1'b1;
              report_clear <= 1'b1;
              state        <= S_CLEAR;
            end else if (invalid) begin
              done           <= 1'b1;
              status         <= ST_INVALID;
              overflow_slots <= '0;
            end else begin
              node_start <= NODE_W'(entry_node);
              dst_q      <= NODE_W'(dst_node);
              port_last  <= PORT_W'({1'b0, dst_host} + 3'd1);
              period_q   <= flow_period;
              pkts       <= pkt_count;
              undo       <= 1'b0;
              state      <= S_DIVMOD;
            end
          end
        end
        S_DIVMOD: begin
          if (div_rsp.done) begin
            first_base <= first_next;
            state      <= S_DIVREP;
          end
        end
        S_DIVREP: begin
          if (div_rsp.done) begin
            reps <= div_rsp.quotient;
            if (div_rsp.quotient == '0) begin
              done           <= 1'b1;
              status         <= ST_ADMITTED;
              overflow_slots <= '0;
              state          <= S_IDLE;
            end else begin
              node     <= node_start;
              hop_base <= first_base;
              slot     <= first_base;
              j        <= '0;
              state    <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (j == reps - 1'b1) begin
            j <= '0;
            if (last_hop) begin
              state <= S_DRAIN;
            end else begin
              node     <= node_next;
              hop_base <= hop_next;
              slot     <= hop_next;
            end
          end else begin
            j    <= j + 1'b1;
            slot <= slot_step;
          end
        end
        S_DRAIN: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (clearing) begin
            clearing     <= 1'b0;
            report_clear <= 1'b0;
            if (report_clear) begin
              done           <= 1'b1;
              status         <= ST_CLEARED;
              overflow_slots <= '0;
            end
            state <= S_IDLE;
          end else if (!undo && over != '0) begin
            undo     <= 1'b1;
            node     <= node_start;
            hop_base <= first_base;
            slot     <= first_base;
            j        <= '0;
            state    <= S_WALK;
          end else begin
            done           <= 1'b1;
            status         <= undo ? ST_REJECTED : ST_ADMITTED;
            overflow_slots <= over;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/cqf_slot_reservation_admission.sv */
// Top level of the cyclic queuing slot admission engine.
//
// Command channel: an item transfers at a clock edge where start is high
// and busy is low. Each item yields one result, shown for one cycle with
// done high on status and overflow_slots; the receiver cannot stall it.
// Config channel: cfg_index 0 writes cycle_slots, 1 writes queue_capacity;
// cfg_ready is always high, writes are meant for idle periods.
// Per admit item: two divider runs, then one store entry per cycle over
// H hops times R = cycle_slots / flow_period entries, then the S_DRAIN
// and S_CHECK states; a rejected request walks the path twice. Invalid
// requests answer in the next cycle without going busy. The single read
// and write port of the occupancy memory sets the walk rate.
// A clear item sweeps the whole memory, all 2**(node+port+slot address
// bits) entries, then reports. After reset the same sweep runs with busy
// high and no result; config writes are still taken during it.
module cqf_slot_reservation_admission #(
  parameter int NODES = 8,
  parameter int PORTS = 4,
  parameter int SLOTS = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [2:0]                entry_node,
  input  logic [2:0]                dst_node,
  input  logic [1:0]                dst_host,
  input  logic [cqf_pkg::OFS_W-1:0] start_offset,
  input  logic [cqf_pkg::DIV_W-1:0] flow_period,
  input  logic [cqf_pkg::PKT_W-1:0] pkt_count,
  output logic                      done,
  output cqf_pkg::status_t          status,
  output logic [cqf_pkg::OVF_W-1:0] overflow_slots,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [cqf_pkg::CFG_W-1:0] cfg_data
);
  import cqf_pkg::*;

  localparam int ADDR_W = $clog2(NODES) + $clog2(PORTS) + $clog2(SLOTS);

  logic [DIV_W-1:0]  cycle_slots;
  logic [CAP_W-1:0]  queue_capacity;
  acc_t              acc;
  logic [ADDR_W-1:0] addr;
  logic [PKT_W-1:0]  pkts;
  logic [OVF_W-1:0]  over;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_slots    <= CYCLE_RESET;
      queue_capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CYCLE:    cycle_slots    <= cfg_data[DIV_W-1:0];
        CFG_CAPACITY: queue_capacity <= cfg_data[CAP_W-1:0];
        default:      ;
      endcase
    end
  end

  cqf_seq #(
    .NODES(NODES),
    .PORTS(PORTS),
    .SLOTS(SLOTS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .entry_node     (entry_node),
    .dst_node       (dst_node),
    .dst_host       (dst_host),
    .start_offset   (start_offset),
    .flow_period    (flow_period),
    .pkt_count      (pkt_count),
    .cycle_slots    (cycle_slots),
    .acc            (acc),
    .addr           (addr),
    .pkts           (pkts),
    .over           (over),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .done           (done),
    .status         (status),
    .overflow_slots (overflow_slots)
  );

  cqf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cqf_store #(
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .addr     (addr),
    .pkts     (pkts),
    .capacity (queue_capacity),
    .over     (over)
  );

endmodule

/* hw/rtl/cqf_checker.sv */
// Port-level checks of the admission engine, bound to the top level.
module cqf_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      kind,
  input logic                      done,
  input logic [1:0]                status,
  input logic [cqf_pkg::OVF_W-1:0] overflow_slots
);
  import cqf_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_admit_clean: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_ADMITTED |-> overflow_slots == '0)
    else $error("admitted flow reports overflow");

  a_reject_count: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_REJECTED |-> overflow_slots != '0)
    else $error("rejected flow without overflow");

  a_no_count: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_INVALID || status == ST_CLEARED) |-> overflow_slots == '0)
    else $error("invalid or clear result carries a count");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == KIND_CLEAR |=> busy)
    else $error("clear transfer did not start a sweep");

endmodule

bind cqf_slot_reservation_admission cqf_checker u_checker (.*);
